// ===== rtl/mqufi_pkg.sv =====
// Package for the multi-queue with urgent front insert.
// Holds the sizes, request and response structs, result codes and FSM states.
// Used by the top level and by its checker; depends on nothing else.
`default_nettype none

package mqufi_pkg;

  // Bank sizing.
  localparam int NUM_QUEUES  = 16;
  localparam int QUEUE_DEPTH = 8;
  localparam int TAG_BITS    = 16;

  // Fixed widths of the request and response fields.
  localparam int QSEL_W = 4;
  localparam int TAG_W  = 16;
  localparam int FILL_W = 4;
  localparam int CODE_W = 2;

  // Derived widths.
  localparam int QIDX_W  = $clog2(NUM_QUEUES);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  localparam logic [CODE_W-1:0] RC_ADDED = 2'd0;
  localparam logic [CODE_W-1:0] RC_FULL  = 2'd1;
  localparam logic [CODE_W-1:0] RC_TAKEN = 2'd2;
  localparam logic [CODE_W-1:0] RC_EMPTY = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [QSEL_W-1:0] queue_sel;
    logic [TAG_W-1:0]  entry_tag;
    logic              urgent;
  } mq_req_t;

  typedef struct packed {
    logic [CODE_W-1:0] result_code;
    logic [TAG_W-1:0]  out_tag;
    logic              out_urgent;
    logic [FILL_W-1:0] fill_after;
  } mq_rsp_t;

  // Per-queue descriptor: ring position of the head and number of entries held.
  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [CNT_W-1:0] fill;
  } mq_desc_t;

  typedef struct packed {
    logic                urgent;
    logic [TAG_BITS-1:0] tag;
  } mq_slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DESC,
    ST_SLOT
  } mq_state_t;

endpackage

`default_nettype wire

// ===== rtl/multi_queue_with_urgent_front_insert.sv =====
// Usage
// A bank of NUM_QUEUES bounded queues of QUEUE_DEPTH entries each. Each request on
// the in_ channel (in_valid, in_stall, in_data) either adds a tag to the addressed
// queue, at the head when urgent is set and at the tail otherwise, or takes the
// head entry. Every request gives exactly one response on the out_ channel
// (out_valid, out_stall, out_data) with the result code and the queue's new fill.
// Each request passes through registered steps: the descriptor memory is read
// into a register on accept, and in ST_DESC an add, a full or an empty answer is
// loaded into the output register; a successful take instead reads the slot memory
// into a register there and loads its response in ST_SLOT. The block works on one
// request at a time and accepts no new request until the last one's response is
// loaded into the output register.
// A finished response sits in the output register while the next request is
// accepted; that request waits before its update until the output is free.
// Reset clears every queue to empty at once through per-queue valid bits on the
// descriptor memory; the slot memory needs no clearing.
// While a response is stalled it holds, and the request behind it changes no
// queue state until the response has been taken.
// Holds the whole datapath and control; depends on mqufi_pkg.
`default_nettype none

module multi_queue_with_urgent_front_insert
  import mqufi_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire mq_req_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output mq_rsp_t      out_data
);

  mq_state_t state_r, state_nxt;
  mq_req_t   req_r;
  logic      in_acc;
  logic      out_free;
  logic      out_load;
  mq_rsp_t   out_rsp;
  logic      out_valid_r;
  mq_rsp_t   out_data_r;

  // Descriptor memory with reset valid bits.
  mq_desc_t                desc_mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0]   desc_vld_r;
  mq_desc_t                desc_rdata_r;
  logic                    desc_hit_r;
  logic                    desc_we;
  mq_desc_t                desc_wdata;
  mq_desc_t                cur;

  // Slot memory: entry tag and urgent mark.
  mq_slot_t                slot_mem [NUM_QUEUES * QUEUE_DEPTH];
  mq_slot_t                slot_rdata_r;
  logic                    slot_we;
  logic                    slot_re;
  logic [SLOT_AW-1:0]      slot_addr;
  mq_slot_t                slot_wdata;

  logic [CNT_W-1:0]        pend_fill_r, pend_fill_nxt;

  logic [QIDX_W-1:0]       q_idx;
  logic                    q_ok;
  logic [SLOT_AW-1:0]      slot_base;
  logic [PTR_W-1:0]        head_inc;
  logic [PTR_W-1:0]        head_dec;
  logic [CNT_W:0]          tail_sum;
  logic [PTR_W-1:0]        tail_pos;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign q_idx = req_r.queue_sel[QIDX_W-1:0];
  assign q_ok  = ({1'b0, req_r.queue_sel} < (QSEL_W + 1)'(NUM_QUEUES));

  // A queue never written since reset reads as empty with its head at zero.
  assign cur = desc_hit_r ? desc_rdata_r : '0;

  assign slot_base = SLOT_AW'(q_idx) * SLOT_AW'(QUEUE_DEPTH);
  assign head_inc  = (cur.head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur.head + 1'b1;
  assign head_dec  = (cur.head == '0) ? PTR_W'(QUEUE_DEPTH - 1) : cur.head - 1'b1;
  assign tail_sum  = (CNT_W + 1)'(cur.head) + (CNT_W + 1)'(cur.fill);
  assign tail_pos  = (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) ?
                     PTR_W'(tail_sum - (CNT_W + 1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      desc_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (out_valid_r && out_stall) || out_load;
      if (desc_we) begin
        desc_vld_r[q_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_fill_r <= pend_fill_nxt;
    if (in_acc) begin
      req_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= out_rsp;
    end
  end

  // Descriptor memory: read on accept, written back in the update cycle.
  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[q_idx] <= desc_wdata;
    end
    if (in_acc) begin
      desc_rdata_r <= desc_mem[in_data.queue_sel[QIDX_W-1:0]];
      desc_hit_r   <= desc_vld_r[in_data.queue_sel[QIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_addr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rdata_r <= slot_mem[slot_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_load      = 1'b0;
    out_rsp       = '0;
    desc_we       = 1'b0;
    desc_wdata    = '0;
    slot_we       = 1'b0;
    slot_re       = 1'b0;
    slot_addr     = '0;
    slot_wdata    = '0;
    pend_fill_nxt = pend_fill_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DESC;
        end
      end

      ST_DESC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          if (!q_ok) begin
            out_load            = 1'b1;
            out_rsp.result_code = (req_r.req_type == REQ_TAKE) ? RC_EMPTY : RC_FULL;
          end else if (req_r.req_type == REQ_TAKE) begin
            if (cur.fill == '0) begin
              out_load            = 1'b1;
              out_rsp.result_code = RC_EMPTY;
            end else begin
              slot_re         = 1'b1;
              slot_addr       = slot_base + SLOT_AW'(cur.head);
              desc_we         = 1'b1;
              desc_wdata.head = head_inc;
              desc_wdata.fill = cur.fill - 1'b1;
              pend_fill_nxt   = cur.fill - 1'b1;
              state_nxt       = ST_SLOT;
            end
          end else if (cur.fill >= CNT_W'(QUEUE_DEPTH)) begin
            out_load            = 1'b1;
            out_rsp.result_code = RC_FULL;
            out_rsp.fill_after  = FILL_W'(cur.fill);
          end else begin
            slot_we           = 1'b1;
            slot_addr         = slot_base + SLOT_AW'(req_r.urgent ? head_dec : tail_pos);
            slot_wdata.tag    = req_r.entry_tag[TAG_BITS-1:0];
            slot_wdata.urgent = req_r.urgent;
            desc_we           = 1'b1;
            desc_wdata.head   = req_r.urgent ? head_dec : cur.head;
            desc_wdata.fill   = cur.fill + 1'b1;
            out_load            = 1'b1;
            out_rsp.result_code = RC_ADDED;
            out_rsp.fill_after  = FILL_W'(cur.fill + 1'b1);
          end
        end
      end

      ST_SLOT: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_rsp.result_code = RC_TAKEN;
          out_rsp.out_tag     = TAG_W'(slot_rdata_r.tag);
          out_rsp.out_urgent  = slot_rdata_r.urgent;
          out_rsp.fill_after  = FILL_W'(pend_fill_r);
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mqufi_chk.sv =====
// Port-level checker for the multi-queue with urgent front insert.
// Bound to the top level; depends on mqufi_pkg.
`default_nettype none

module mqufi_chk
  import mqufi_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst_n,
  input wire logic    in_valid,
  input wire logic    in_stall,
  input wire logic    out_valid,
  input wire logic    out_stall,
  input wire mq_rsp_t out_data
);

  // A stalled response stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled response withdrawn or changed");

  // The block works on one request at a time.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in progress");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fill_after <= FILL_W'(QUEUE_DEPTH))
    else $error("fill beyond queue depth");

  // An empty answer carries nothing; an add always leaves at least one entry.
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_code == RC_EMPTY |->
      out_data.fill_after == '0 && out_data.out_tag == '0 && !out_data.out_urgent)
    else $error("empty response not clean");

  a_added_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_code == RC_ADDED |->
      out_data.fill_after != '0 && out_data.out_tag == '0 && !out_data.out_urgent)
    else $error("add response malformed");

endmodule

bind multi_queue_with_urgent_front_insert mqufi_chk u_mqufi_chk (.*);

`default_nettype wire
